/* design/scpr_pkg.sv */
`default_nettype none

package scpr_pkg;

    // Width of every level, fill and history sample.
    localparam int LevelW = 7;

    // Item kinds.
    localparam logic CmdPush  = 1'b0;
    localparam logic CmdPixel = 1'b1;

    // Full scale of all levels and the motion floor below which the graph
    // falls back to half the RSSI fill.
    localparam logic [LevelW-1:0] FullScale  = 7'd100;
    localparam logic [LevelW-1:0] MinVisible = 7'd2;

    // Gains applied to the Q8.8 motion and presence inputs.
    localparam logic [4:0] MotionGain   = 5'd18;
    localparam logic [2:0] PresenceGain = 3'd6;

    // RSSI fill is (rssi + 100) * 100 / 60 = (rssi + 100) * 5 / 3.
    localparam logic [7:0] RssiOffset = 8'd100;
    localparam logic [7:0] RssiSpan   = 8'd60;
    localparam logic [3:0] RssiNum    = 4'd5;

    // Division by three as a multiply by 171 and a shift by 9. Exact for
    // every dividend below 512.
    localparam logic [7:0] RecipThird = 8'd171;
    localparam int         RecipShift = 9;

    // Rows taken by the battery bar at the top and the RSSI bar at the bottom.
    localparam int BandTop    = 8;
    localparam int BandBottom = 8;

    // Levels produced by one push.
    typedef struct packed {
        logic [LevelW-1:0] graph;
        logic [LevelW-1:0] motion;
        logic [LevelW-1:0] rssi;
        logic [LevelW-1:0] battery;
    } levels_t;

    // Saturate a non-negative value at full scale.
    function automatic logic [LevelW-1:0] sat_level(input logic [11:0] v);
        logic [LevelW-1:0] r;
        if (v > 12'(FullScale))
            r = FullScale;
        else
            r = v[LevelW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/scpr_levels.sv */
`default_nettype none

module scpr_levels (
    input  logic signed [15:0]   motion_q,
    input  logic signed [15:0]   presence_q,
    input  logic signed [7:0]    rssi_dbm,
    input  logic                 vitals_ok,
    input  logic [6:0]           battery_percent,
    input  logic                 batt_ok,
    output scpr_pkg::levels_t    levels
);
    import scpr_pkg::*;

    logic              me_pos;
    logic              ps_pos;
    logic [19:0]       me_prod;
    logic [17:0]       ps_prod;
    logic [LevelW-1:0] motion_me;
    logic [LevelW-1:0] motion_v;
    logic [LevelW-1:0] motion;
    logic signed [8:0] rs;
    logic [8:0]        rs_x5;
    logic [15:0]       rs_div;
    logic [LevelW-1:0] rfill_v;
    logic [LevelW-1:0] rfill;
    logic [LevelW-1:0] batt;

    // Motion from energy; positive products shifted right truncate toward zero.
    assign me_pos  = !motion_q[15] && (motion_q != 16'sd0);
    assign ps_pos  = !presence_q[15] && (presence_q != 16'sd0);
    assign me_prod = 20'(motion_q[14:0]) * 20'(MotionGain);
    assign ps_prod = 18'(presence_q[14:0]) * 18'(PresenceGain);

    assign motion_me = me_pos ? sat_level(me_prod[19:8]) : '0;

    // Presence takes over when the motion is too weak to show.
    assign motion_v = (motion_me < MinVisible && ps_pos) ?
                      sat_level(12'(ps_prod[17:8])) : motion_me;
    assign motion   = vitals_ok ? motion_v : '0;

    // RSSI fill: zero at or below -100 dBm, full at -40 dBm and above.
    assign rs     = {rssi_dbm[7], rssi_dbm} + $signed({1'b0, RssiOffset});
    assign rs_x5  = 9'(rs[5:0]) * 9'(RssiNum);
    assign rs_div = (16'(rs_x5) * 16'(RecipThird)) >> RecipShift;

    always_comb
    begin
        if (rs[8] || rs == 9'sd0)
            rfill_v = '0;
        else if (rs[7:0] >= RssiSpan)
            rfill_v = FullScale;
        else
            rfill_v = rs_div[LevelW-1:0];
    end

    assign rfill = vitals_ok ? rfill_v : '0;

    // Battery fill, saturated at full scale.
    always_comb
    begin
        if (!batt_ok)
            batt = '0;
        else if (battery_percent > FullScale)
            batt = FullScale;
        else
            batt = battery_percent;
    end

    // Graph shows half the RSSI fill when motion is weak.
    assign levels.graph   = (motion < MinVisible) ? (rfill >> 1) : motion;
    assign levels.motion  = motion;
    assign levels.rssi    = rfill;
    assign levels.battery = batt;

endmodule

`default_nettype wire

/* design/scpr_history.sv */
`default_nettype none

module scpr_history #(
    parameter int WIDTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        rd_en,
    input  logic [7:0]                  pixel_x,
    input  logic                        wr_en,
    input  logic [$clog2(WIDTH)-1:0]    wr_addr,
    input  logic [scpr_pkg::LevelW-1:0] wr_data,
    output logic [$clog2(WIDTH)-1:0]    head,
    output logic [scpr_pkg::LevelW-1:0] sample
);
    import scpr_pkg::*;

    localparam int AW = $clog2(WIDTH);
    localparam int FW = $clog2(WIDTH + 1);
    localparam int SW = ((AW > 8) ? AW : 8) + 1;

    logic [LevelW-1:0] mem [WIDTH];
    logic [LevelW-1:0] rd_reg;
    logic [LevelW-1:0] fwd_reg;
    logic              hit_reg;
    logic              valid_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic [SW-1:0]     sum;
    logic [SW-1:0]     idx_full;
    logic [AW-1:0]     rd_addr;
    logic              rd_hit;
    logic              rd_valid;

    // Ring pointer and count of entries written since reset. Writes go in
    // order from entry zero, so entries below the count hold data and the
    // rest still read as zero.
    assign head_next = (head_reg == AW'(WIDTH - 1)) ? '0 : head_reg + AW'(1);
    assign fill_next = (fill_reg == FW'(WIDTH)) ? fill_reg : fill_reg + FW'(1);

    // Oldest sample sits at the left column. Columns outside the panel give
    // a wrong index, but their pixel is dark anyway.
    assign sum      = SW'(head_reg) + SW'(pixel_x);
    assign idx_full = (sum >= SW'(WIDTH)) ? sum - SW'(WIDTH) : sum;
    assign rd_addr  = idx_full[AW-1:0];
    assign rd_hit   = wr_en && (wr_addr == rd_addr);
    assign rd_valid = FW'(rd_addr) < fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            fill_reg  <= '0;
            hit_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                head_reg <= head_next;
                fill_reg <= fill_next;
            end
            if (rd_en)
            begin
                hit_reg   <= rd_hit;
                valid_reg <= rd_valid;
            end
        end
    end

    // Sample memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // A push that retires on the read edge is forwarded past the memory.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            fwd_reg <= wr_data;
    end

    assign head   = head_reg;
    assign sample = !valid_reg ? '0 : (hit_reg ? fwd_reg : rd_reg);

endmodule

`default_nettype wire

/* design/scpr_pixel.sv */
`default_nettype none

module scpr_pixel #(
    parameter int WIDTH  = 256,
    parameter int HEIGHT = 128
) (
    input  logic [7:0]                  pixel_x,
    input  logic [6:0]                  pixel_y,
    input  logic [scpr_pkg::LevelW-1:0] sample,
    input  logic [scpr_pkg::LevelW-1:0] battery_bar,
    input  logic [scpr_pkg::LevelW-1:0] rssi_bar,
    output logic                        pixel_on
);
    import scpr_pkg::*;

    localparam int BarW  = $clog2(100 * (WIDTH + 256) + 1);
    localparam int PlotW = $clog2(100 * HEIGHT + 1);
    localparam int YW    = $clog2(HEIGHT + 128);

    logic              in_panel;
    logic              top_band;
    logic              bot_band;
    logic [LevelW-1:0] fill;
    logic [BarW-1:0]   bar_lhs;
    logic [BarW-1:0]   bar_rhs;
    logic              bar_on;
    logic [YW-1:0]     thr;
    logic [PlotW-1:0]  plot_lhs;
    logic [PlotW-1:0]  plot_rhs;
    logic              plot_on;

    // Band decode.
    assign in_panel = (BarW'(pixel_x) < BarW'(WIDTH)) && (YW'(pixel_y) < YW'(HEIGHT));
    assign top_band = YW'(pixel_y) < YW'(BandTop);
    assign bot_band = YW'(pixel_y) >= YW'(HEIGHT - BandBottom);

    // Bars: x < fill * WIDTH / 100 is the same as (x + 1) * 100 <= fill * WIDTH.
    assign fill    = top_band ? battery_bar : rssi_bar;
    assign bar_lhs = (BarW'(pixel_x) + BarW'(1)) * BarW'(FullScale);
    assign bar_rhs = BarW'(fill) * BarW'(WIDTH);
    assign bar_on  = bar_lhs <= bar_rhs;

    // Plot: sample * plot height / 100 >= rows above the plot bottom, with
    // the division moved to the other side.
    assign thr      = YW'(HEIGHT - BandBottom) - YW'(pixel_y);
    assign plot_lhs = PlotW'(sample) * PlotW'(HEIGHT - BandTop - BandBottom);
    assign plot_rhs = PlotW'(FullScale) * PlotW'(thr);
    assign plot_on  = plot_lhs >= plot_rhs;

    assign pixel_on = in_panel && ((top_band || bot_band) ? bar_on : plot_on);

endmodule

`default_nettype wire

/* design/strip_chart_pixel_renderer_core.sv */
`default_nettype none

// Channel  Handshake            Beat contents
// -------  -------------------  --------------------------------------------------
// in       in_valid / in_ready  cmd, readings (push) or pixel_x, pixel_y (pixel)
// out      out_valid/out_ready  pixel_on, graph_value, motion_level, rssi_level,
//                               battery_level
//
// One beat is accepted every cycle while in_ready is high; its result is on
// out once it has passed the input register into the result register. A pixel
// beat's history read is issued on its accept edge from the single memory read
// port.
// Reset clears the history, ring pointer and bars at once; no start-up sweep.
// A stall on out holds both registers; in_ready drops only when both are full.
module strip_chart_pixel_renderer_core #(
    parameter int WIDTH  = 256,
    parameter int HEIGHT = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic signed [15:0]          motion_q,
    input  logic signed [15:0]          presence_q,
    input  logic signed [7:0]           rssi_dbm,
    input  logic                        vitals_ok,
    input  logic [6:0]                  battery_percent,
    input  logic                        batt_ok,
    input  logic [7:0]                  pixel_x,
    input  logic [6:0]                  pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pixel_on,
    output logic [6:0]                  graph_value,
    output logic [6:0]                  motion_level,
    output logic [6:0]                  rssi_level,
    output logic [6:0]                  battery_level
);
    import scpr_pkg::*;

    localparam int AW = $clog2(WIDTH);

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] me;
        logic signed [15:0] ps;
        logic signed [7:0]  rssi;
        logic               vit;
        logic [6:0]         batt;
        logic               hb;
        logic [7:0]         x;
        logic [6:0]         y;
        logic [AW-1:0]      waddr;
    } item_t;

    item_t             s1_reg;
    item_t             s1_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_move;
    logic              in_fire;
    logic              push_fire;
    logic              pix_fire;
    logic              wr_en;
    logic [AW-1:0]     head;
    logic [LevelW-1:0] sample;
    logic              pix_on;
    levels_t           lv;
    logic [LevelW-1:0] batt_bar_reg;
    logic [LevelW-1:0] rssi_bar_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              pixel_on_reg;
    levels_t           out_lv_reg;

    // Handshake: the input register refills whenever it empties into the
    // result register.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_fire   = in_valid && in_ready;
    assign push_fire = in_fire && (cmd == CmdPush);
    assign pix_fire  = in_fire && (cmd == CmdPixel);
    assign wr_en     = s1_move && (s1_reg.cmd == CmdPush);

    // Input register contents.
    always_comb
    begin
        s1_next.cmd   = cmd;
        s1_next.me    = motion_q;
        s1_next.ps    = presence_q;
        s1_next.rssi  = rssi_dbm;
        s1_next.vit   = vitals_ok;
        s1_next.batt  = battery_percent;
        s1_next.hb    = batt_ok;
        s1_next.x     = pixel_x;
        s1_next.y     = pixel_y;
        s1_next.waddr = head;
    end

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            batt_bar_reg  <= '0;
            rssi_bar_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // Bars change as a push retires, ahead of any later pixel beat.
            if (wr_en)
            begin
                batt_bar_reg <= lv.battery;
                rssi_bar_reg <= lv.rssi;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= s1_next;
        if (s1_move)
        begin
            if (s1_reg.cmd == CmdPush)
            begin
                pixel_on_reg <= 1'b0;
                out_lv_reg   <= lv;
            end
            else
            begin
                pixel_on_reg <= pix_on;
                out_lv_reg   <= '0;
            end
        end
    end

    // Level arithmetic for a push.
    scpr_levels u_levels (
        .motion_q        (s1_reg.me),
        .presence_q      (s1_reg.ps),
        .rssi_dbm        (s1_reg.rssi),
        .vitals_ok       (s1_reg.vit),
        .battery_percent (s1_reg.batt),
        .batt_ok         (s1_reg.hb),
        .levels          (lv)
    );

    // History ring.
    scpr_history #(
        .WIDTH (WIDTH)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push_fire),
        .rd_en   (pix_fire),
        .pixel_x (pixel_x),
        .wr_en   (wr_en),
        .wr_addr (s1_reg.waddr),
        .wr_data (lv.graph),
        .head    (head),
        .sample  (sample)
    );

    // Pixel decision for a pixel beat.
    scpr_pixel #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_pixel (
        .pixel_x     (s1_reg.x),
        .pixel_y     (s1_reg.y),
        .sample      (sample),
        .battery_bar (batt_bar_reg),
        .rssi_bar    (rssi_bar_reg),
        .pixel_on    (pix_on)
    );

    assign out_valid     = out_valid_reg;
    assign pixel_on      = pixel_on_reg;
    assign graph_value   = out_lv_reg.graph;
    assign motion_level  = out_lv_reg.motion;
    assign rssi_level    = out_lv_reg.rssi;
    assign battery_level = out_lv_reg.battery;

endmodule

`default_nettype wire
